FILE: rtl/rqvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqvg_pkg
// Shared types, widths and constants of the rotated quad vertex generator.
// ----------------------------------------------------------------------------
package rqvg_pkg;

  // Field and datapath widths.
  localparam int unsigned RES_W    = 13;  // screen resolution registers
  localparam int unsigned COORD_W  = 14;  // center coordinates
  localparam int unsigned SIZE_W   = 12;  // rectangle size
  localparam int unsigned DEG_W    = 9;   // rotation in degrees
  localparam int unsigned COLOR_W  = 32;  // packed RGBA
  localparam int unsigned XY_W     = 34;  // CORDIC x and y, Q2.30 plus headroom
  localparam int unsigned Z_W      = 33;  // CORDIC binary angle
  localparam int unsigned PROD_W   = 47;  // extent times sine or cosine
  localparam int unsigned SUM_W    = 48;  // numerator before scaling
  localparam int unsigned N_W      = 30;  // numerator scaled down by 2^18
  localparam int unsigned M_W      = 31;  // dividend magnitude
  localparam int unsigned Q_W      = 17;  // quotient bits kept before saturation
  localparam int unsigned OUT_W    = 16;  // Q3.12 result
  localparam int unsigned VNUM_W   = 3;   // vertex number

  localparam int unsigned ANGLE_TABLE_LEN = 24;
  localparam int unsigned NUM_CORNERS     = 6;
  localparam int unsigned LAST_CORNER     = 5;
  localparam int unsigned HALF_SHIFT      = 17;  // half divisor is res * 2^17
  localparam int unsigned SCALE_SHIFT     = 18;  // divisor is res * 2^18
  localparam int unsigned CENTER_SHIFT    = 31;  // center times 2 in Q2.30

  localparam logic [XY_W-1:0] CORDIC_GAIN_Q30  = XY_W'(652032874);
  localparam logic [24:0]     UNITS_PER_DEGREE = 25'd11930465;
  localparam logic [18:0]     NDC_ONE          = 19'd4096;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [RES_W-1:0] SCREEN_WIDTH_RST  = 13'd1920;
  localparam logic [RES_W-1:0] SCREEN_HEIGHT_RST = 13'd1080;

  // Rectangle data that rides along the rotation chain.
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COLOR_W-1:0] color;
    logic               flip;
  } rect_t;

  // Vertex data that rides along the divider chain.
  typedef struct packed {
    logic [VNUM_W-1:0]  num;
    logic               last;
    logic [COLOR_W-1:0] color;
    logic               neg_x;
    logic               ovf_x;
    logic               neg_y;
    logic               ovf_y;
  } vtx_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Corner sign of the x half-extent: left corners are negative.
  function automatic logic corner_x_neg(input logic [VNUM_W-1:0] k);
    return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
  endfunction

  // Corner sign of the y half-extent: bottom corners are negative.
  function automatic logic corner_y_neg(input logic [VNUM_W-1:0] k);
    return (k == 3'd0) || (k == 3'd1) || (k == 3'd3);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rqvg_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqvg_cordic_cell
// One rotation step of the CORDIC chain with its rectangle payload.
// ----------------------------------------------------------------------------
module rqvg_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic signed [rqvg_pkg::XY_W-1:0] x_i,
  input  wire logic signed [rqvg_pkg::XY_W-1:0] y_i,
  input  wire logic signed [rqvg_pkg::Z_W-1:0]  z_i,
  input  wire rqvg_pkg::rect_t                  rect_i,
  output logic                                  valid_o,
  output logic signed [rqvg_pkg::XY_W-1:0]      x_o,
  output logic signed [rqvg_pkg::XY_W-1:0]      y_o,
  output logic signed [rqvg_pkg::Z_W-1:0]       z_o,
  output rqvg_pkg::rect_t                       rect_o
);

  localparam logic signed [rqvg_pkg::Z_W-1:0] ANGLE =
    $signed(rqvg_pkg::Z_W'(rqvg_pkg::atan_entry(STAGE)));

  logic signed [rqvg_pkg::XY_W-1:0] xs, ys, x_d, y_d;
  logic signed [rqvg_pkg::Z_W-1:0]  z_d;
  logic                             valid_q;
  logic signed [rqvg_pkg::XY_W-1:0] x_q, y_q;
  logic signed [rqvg_pkg::Z_W-1:0]  z_q;
  rqvg_pkg::rect_t                  rect_q;

  // Rotate toward the residual angle; arithmetic shifts round toward minus infinity.
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[rqvg_pkg::Z_W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANGLE;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANGLE;
    end
  end

  // Valid bit is control state; the datapath carries no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    rect_q <= rect_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign rect_o  = rect_q;

endmodule
`default_nettype wire

FILE: rtl/rqvg_vertex_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqvg_vertex_seq
// Walks the six corners of a rectangle, rotates the half-extents and forms
// the scaled numerators and dividend magnitudes for the divider chain.
// ----------------------------------------------------------------------------
module rqvg_vertex_seq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic signed [rqvg_pkg::XY_W-1:0] cos_i,
  input  wire logic signed [rqvg_pkg::XY_W-1:0] sin_i,
  input  wire rqvg_pkg::rect_t                  rect_i,
  input  wire logic [rqvg_pkg::RES_W-1:0]       res_x_i,
  input  wire logic [rqvg_pkg::RES_W-1:0]       res_y_i,
  output logic                                  valid_o,
  output logic [rqvg_pkg::M_W-1:0]              mag_x_o,
  output logic [rqvg_pkg::M_W-1:0]              mag_y_o,
  output rqvg_pkg::vtx_t                        vtx_o
);

  localparam int unsigned PROD_W = rqvg_pkg::PROD_W;
  localparam int unsigned SUM_W  = rqvg_pkg::SUM_W;
  localparam int unsigned N_W    = rqvg_pkg::N_W;
  localparam int unsigned M_W    = rqvg_pkg::M_W;
  localparam int unsigned SIZE_W = rqvg_pkg::SIZE_W;

  // Held rectangle and corner counter.
  logic                             active_q;
  logic [rqvg_pkg::VNUM_W-1:0]      num_q;
  logic signed [rqvg_pkg::XY_W-1:0] c_q, s_q;
  rqvg_pkg::rect_t                  rect_q;

  // Flip undoes the half-turn reduction of the angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      num_q    <= '0;
    end else if (valid_i) begin
      active_q <= 1'b1;
      num_q    <= '0;
    end else if (active_q) begin
      active_q <= (num_q != rqvg_pkg::VNUM_W'(rqvg_pkg::LAST_CORNER));
      num_q    <= num_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      c_q    <= rect_i.flip ? -cos_i : cos_i;
      s_q    <= rect_i.flip ? -sin_i : sin_i;
      rect_q <= rect_i;
    end
  end

  // Stage A: signed extents of the current corner times cosine and sine.
  logic signed [SIZE_W:0]   ex, ey;
  logic                     a_valid_q;
  logic signed [PROD_W-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic [rqvg_pkg::COORD_W-1:0] a_cx_q, a_cy_q;
  rqvg_pkg::vtx_t           a_vtx_q;

  always_comb begin
    ex = $signed({1'b0, rect_q.w});
    ey = $signed({1'b0, rect_q.h});
    if (rqvg_pkg::corner_x_neg(num_q)) begin
      ex = -ex;
    end
    if (rqvg_pkg::corner_y_neg(num_q)) begin
      ey = -ey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xc_q  <= ex * c_q;
    p_ys_q  <= ey * s_q;
    p_xs_q  <= ex * s_q;
    p_yc_q  <= ey * c_q;
    a_cx_q  <= rect_q.cx;
    a_cy_q  <= rect_q.cy;
    a_vtx_q <= '{num:   num_q,
                 last:  (num_q == rqvg_pkg::VNUM_W'(rqvg_pkg::LAST_CORNER)),
                 color: rect_q.color,
                 neg_x: 1'b0,
                 ovf_x: 1'b0,
                 neg_y: 1'b0,
                 ovf_y: 1'b0};
  end

  // Stage B: numerator plus half divisor, then floor division by 2^18.
  logic signed [SUM_W-1:0] half_x, half_y, t_x, t_y;
  logic                    b_valid_q;
  logic signed [N_W-1:0]   n_x_q, n_y_q;
  rqvg_pkg::vtx_t          b_vtx_q;

  always_comb begin
    half_x = $signed({18'b0, res_x_i, 17'b0});
    half_y = $signed({18'b0, res_y_i, 17'b0});
    t_x = (SUM_W'($signed(a_cx_q)) <<< rqvg_pkg::CENTER_SHIFT)
        + SUM_W'(p_xc_q) - SUM_W'(p_ys_q) + half_x;
    t_y = (SUM_W'($signed(a_cy_q)) <<< rqvg_pkg::CENTER_SHIFT)
        + SUM_W'(p_xs_q) + SUM_W'(p_yc_q) + half_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_x_q   <= t_x[SUM_W-1:rqvg_pkg::SCALE_SHIFT];
    n_y_q   <= t_y[SUM_W-1:rqvg_pkg::SCALE_SHIFT];
    b_vtx_q <= a_vtx_q;
  end

  // Stage C: magnitude for floor division and early overflow detection.
  // A negative dividend becomes -n + res - 1 so that its truncated
  // quotient is the ceiling that floor division needs.
  logic [M_W-1:0] res_x_ext, res_y_ext, m_x, m_y;
  logic           neg_x, neg_y;
  logic           c_valid_q;
  logic [M_W-1:0] m_x_q, m_y_q;
  rqvg_pkg::vtx_t c_vtx_q;

  always_comb begin
    res_x_ext = M_W'(res_x_i);
    res_y_ext = M_W'(res_y_i);
    neg_x = n_x_q[N_W-1];
    neg_y = n_y_q[N_W-1];
    m_x = neg_x ? (res_x_ext - M_W'(n_x_q) - M_W'(1)) : M_W'(n_x_q);
    m_y = neg_y ? (res_y_ext - M_W'(n_y_q) - M_W'(1)) : M_W'(n_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_x_q   <= m_x;
    m_y_q   <= m_y;
    c_vtx_q <= '{num:   b_vtx_q.num,
                 last:  b_vtx_q.last,
                 color: b_vtx_q.color,
                 neg_x: neg_x,
                 ovf_x: ((m_x >> rqvg_pkg::Q_W) >= res_x_ext),
                 neg_y: neg_y,
                 ovf_y: ((m_y >> rqvg_pkg::Q_W) >= res_y_ext)};
  end

  assign valid_o = c_valid_q;
  assign mag_x_o = m_x_q;
  assign mag_y_o = m_y_q;
  assign vtx_o   = c_vtx_q;

endmodule
`default_nettype wire

FILE: rtl/rqvg_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqvg_div_cell
// One restoring-division step for both axes: produces one quotient bit each.
// ----------------------------------------------------------------------------
module rqvg_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [rqvg_pkg::RES_W-1:0]   res_x_i,
  input  wire logic [rqvg_pkg::RES_W-1:0]   res_y_i,
  input  wire logic [rqvg_pkg::M_W-1:0]     rem_x_i,
  input  wire logic [rqvg_pkg::M_W-1:0]     rem_y_i,
  input  wire logic [rqvg_pkg::Q_W-1:0]     quo_x_i,
  input  wire logic [rqvg_pkg::Q_W-1:0]     quo_y_i,
  input  wire rqvg_pkg::vtx_t               vtx_i,
  output logic                              valid_o,
  output logic [rqvg_pkg::M_W-1:0]          rem_x_o,
  output logic [rqvg_pkg::M_W-1:0]          rem_y_o,
  output logic [rqvg_pkg::Q_W-1:0]          quo_x_o,
  output logic [rqvg_pkg::Q_W-1:0]          quo_y_o,
  output rqvg_pkg::vtx_t                    vtx_o
);

  localparam int unsigned M_W = rqvg_pkg::M_W;

  logic [M_W-1:0] dx, dy;
  logic           bit_x, bit_y;
  logic           valid_q;
  logic [M_W-1:0] rem_x_q, rem_y_q;
  logic [rqvg_pkg::Q_W-1:0] quo_x_q, quo_y_q;
  rqvg_pkg::vtx_t vtx_q;

  // Trial subtraction of the divisor aligned at this quotient bit.
  always_comb begin
    dx    = M_W'(res_x_i) << BIT;
    dy    = M_W'(res_y_i) << BIT;
    bit_x = (rem_x_i >> BIT) >= M_W'(res_x_i);
    bit_y = (rem_y_i >> BIT) >= M_W'(res_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_x_q <= bit_x ? (rem_x_i - dx) : rem_x_i;
    rem_y_q <= bit_y ? (rem_y_i - dy) : rem_y_i;
    quo_x_q <= {quo_x_i[rqvg_pkg::Q_W-2:0], bit_x};
    quo_y_q <= {quo_y_i[rqvg_pkg::Q_W-2:0], bit_y};
    vtx_q   <= vtx_i;
  end

  assign valid_o = valid_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign quo_x_o = quo_x_q;
  assign quo_y_o = quo_y_q;
  assign vtx_o   = vtx_q;

endmodule
`default_nettype wire

FILE: rtl/rotated_quad_vertex_gen_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_quad_vertex_gen_core
// Turns one rotated rectangle into the six vertices of two triangles.
// ----------------------------------------------------------------------------
// Usage. Pulse start_i with the rectangle fields while busy_o is low; the
// transaction is taken at that edge. busy_o then stays high until the issue
// counter runs out, so a new rectangle can be taken while earlier ones are
// still in flight. Each rectangle yields six vertices on consecutive cycles,
// each shown for one cycle with valid_o high, in the order bottom-left,
// bottom-right, top-right, bottom-left, top-right, top-left; last_vertex_o
// marks the sixth. The receiver cannot stall the output.
// From the accepting edge the first vertex passes one input register, one
// CORDIC cell per stage (up to the length of the angle table), the corner
// sequencer with its counter register and three arithmetic stages, 17 divider
// cells (one quotient bit each) and the output register. Issue spacing matches
// the single corner sequencer, which emits one vertex per cycle.
// Configuration: write screen width (index 0) or height (index 1) with
// cfg_we_i while no rectangle is in flight. Reset clears all valid bits and
// loads the resolution registers with 1920 by 1080.
// ----------------------------------------------------------------------------
module rotated_quad_vertex_gen_core #(
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic signed [13:0]   center_x_i,
  input  wire logic signed [13:0]   center_y_i,
  input  wire logic [11:0]          rect_width_i,
  input  wire logic [11:0]          rect_height_i,
  input  wire logic [8:0]           rotation_deg_i,
  input  wire logic [7:0]           in_red_i,
  input  wire logic [7:0]           in_green_i,
  input  wire logic [7:0]           in_blue_i,
  input  wire logic [7:0]           in_alpha_i,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_addr_i,
  input  wire logic [12:0]          cfg_wdata_i,
  output logic                      valid_o,
  output logic signed [15:0]        vertex_x_o,
  output logic signed [15:0]        vertex_y_o,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic [7:0]                out_alpha_o,
  output logic [2:0]                vertex_number_o,
  output logic                      last_vertex_o
);

  localparam int unsigned NUM_CELLS =
    (ROTATION_STAGES < rqvg_pkg::ANGLE_TABLE_LEN) ? ROTATION_STAGES
                                                  : rqvg_pkg::ANGLE_TABLE_LEN;
  localparam int unsigned XY_W = rqvg_pkg::XY_W;
  localparam int unsigned Z_W  = rqvg_pkg::Z_W;
  localparam int unsigned Q_W  = rqvg_pkg::Q_W;
  localparam int unsigned M_W  = rqvg_pkg::M_W;
  localparam int unsigned RES_W = rqvg_pkg::RES_W;

  // Resolution registers; a zero resolution acts as one.
  logic [RES_W-1:0] screen_width_q, screen_height_q, res_x, res_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= rqvg_pkg::SCREEN_WIDTH_RST;
      screen_height_q <= rqvg_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rqvg_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i;
        rqvg_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign res_x = (screen_width_q == '0) ? RES_W'(1) : screen_width_q;
  assign res_y = (screen_height_q == '0) ? RES_W'(1) : screen_height_q;

  // Issue spacing: busy_o holds off a new rectangle while the gap counter runs.
  logic       accept;
  logic [2:0] gap_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (gap_q != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 3'd0;
    end else if (accept) begin
      gap_q <= 3'(rqvg_pkg::LAST_CORNER);
    end else if (gap_q != 3'd0) begin
      gap_q <= gap_q - 3'd1;
    end
  end

  // Input register: reduce the angle to [-90, 90] degrees and convert it.
  logic signed [9:0]  deg_a, deg_b, deg_c;
  logic               flip;
  logic               in_valid_q;
  logic signed [Z_W-1:0] z0_q;
  rqvg_pkg::rect_t    in_rect_q;

  always_comb begin
    deg_a = $signed({1'b0, rotation_deg_i});
    if (deg_a >= 10'sd360) begin
      deg_a = deg_a - 10'sd360;
    end
    deg_b = (deg_a > 10'sd180) ? (deg_a - 10'sd360) : deg_a;
    flip  = 1'b0;
    deg_c = deg_b;
    if (deg_b > 10'sd90) begin
      deg_c = deg_b - 10'sd180;
      flip  = 1'b1;
    end else if (deg_b < -10'sd90) begin
      deg_c = deg_b + 10'sd180;
      flip  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    z0_q      <= Z_W'(deg_c) * $signed({1'b0, rqvg_pkg::UNITS_PER_DEGREE});
    in_rect_q <= '{cx:    center_x_i,
                   cy:    center_y_i,
                   w:     rect_width_i,
                   h:     rect_height_i,
                   color: {in_red_i, in_green_i, in_blue_i, in_alpha_i},
                   flip:  flip};
  end

  // CORDIC chain.
  logic                  cv [NUM_CELLS+1];
  logic signed [XY_W-1:0] cx_s [NUM_CELLS+1];
  logic signed [XY_W-1:0] cy_s [NUM_CELLS+1];
  logic signed [Z_W-1:0]  cz_s [NUM_CELLS+1];
  rqvg_pkg::rect_t        cr_s [NUM_CELLS+1];

  assign cv[0]   = in_valid_q;
  assign cx_s[0] = $signed(rqvg_pkg::CORDIC_GAIN_Q30);
  assign cy_s[0] = '0;
  assign cz_s[0] = z0_q;
  assign cr_s[0] = in_rect_q;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cordic
    rqvg_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[i]),
      .x_i    (cx_s[i]),
      .y_i    (cy_s[i]),
      .z_i    (cz_s[i]),
      .rect_i (cr_s[i]),
      .valid_o(cv[i+1]),
      .x_o    (cx_s[i+1]),
      .y_o    (cy_s[i+1]),
      .z_o    (cz_s[i+1]),
      .rect_o (cr_s[i+1])
    );
  end

  // Corner sequencer and numerator stages.
  logic           sq_valid;
  logic [M_W-1:0] sq_mx, sq_my;
  rqvg_pkg::vtx_t sq_vtx;

  rqvg_vertex_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cv[NUM_CELLS]),
    .cos_i  (cx_s[NUM_CELLS]),
    .sin_i  (cy_s[NUM_CELLS]),
    .rect_i (cr_s[NUM_CELLS]),
    .res_x_i(res_x),
    .res_y_i(res_y),
    .valid_o(sq_valid),
    .mag_x_o(sq_mx),
    .mag_y_o(sq_my),
    .vtx_o  (sq_vtx)
  );

  // Divider chain, most significant quotient bit first.
  logic           dv [Q_W+1];
  logic [M_W-1:0] drx [Q_W+1];
  logic [M_W-1:0] dry [Q_W+1];
  logic [Q_W-1:0] dqx [Q_W+1];
  logic [Q_W-1:0] dqy [Q_W+1];
  rqvg_pkg::vtx_t dvt [Q_W+1];

  assign dv[0]  = sq_valid;
  assign drx[0] = sq_mx;
  assign dry[0] = sq_my;
  assign dqx[0] = '0;
  assign dqy[0] = '0;
  assign dvt[0] = sq_vtx;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    rqvg_div_cell #(.BIT(Q_W - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[j]),
      .res_x_i(res_x),
      .res_y_i(res_y),
      .rem_x_i(drx[j]),
      .rem_y_i(dry[j]),
      .quo_x_i(dqx[j]),
      .quo_y_i(dqy[j]),
      .vtx_i  (dvt[j]),
      .valid_o(dv[j+1]),
      .rem_x_o(drx[j+1]),
      .rem_y_o(dry[j+1]),
      .quo_x_o(dqx[j+1]),
      .quo_y_o(dqy[j+1]),
      .vtx_o  (dvt[j+1])
    );
  end

  // Output stage: apply sign, remove the NDC offset and saturate.
  function automatic logic signed [15:0] finish(input logic [Q_W-1:0] q,
                                                input logic neg, input logic ovf);
    logic signed [18:0] qs, v;
    logic signed [15:0] r;
    qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    v  = qs - $signed(rqvg_pkg::NDC_ONE);
    if (ovf) begin
      r = neg ? rqvg_pkg::OUT_MIN : rqvg_pkg::OUT_MAX;
    end else if (v > 19'sd32767) begin
      r = rqvg_pkg::OUT_MAX;
    end else if (v < -19'sd32768) begin
      r = rqvg_pkg::OUT_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic               out_valid_q;
  logic signed [15:0] vx_q, vy_q;
  rqvg_pkg::vtx_t     out_vtx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q      <= finish(dqx[Q_W], dvt[Q_W].neg_x, dvt[Q_W].ovf_x);
    vy_q      <= finish(dqy[Q_W], dvt[Q_W].neg_y, dvt[Q_W].ovf_y);
    out_vtx_q <= dvt[Q_W];
  end

  assign valid_o         = out_valid_q;
  assign vertex_x_o      = vx_q;
  assign vertex_y_o      = vy_q;
  assign out_red_o       = out_vtx_q.color[31:24];
  assign out_green_o     = out_vtx_q.color[23:16];
  assign out_blue_o      = out_vtx_q.color[15:8];
  assign out_alpha_o     = out_vtx_q.color[7:0];
  assign vertex_number_o = out_vtx_q.num;
  assign last_vertex_o   = out_vtx_q.last;

endmodule
`default_nettype wire

FILE: rtl/rqvg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqvg_checker
// Port-level checks of the vertex stream and issue spacing.
// ----------------------------------------------------------------------------
module rqvg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       valid_o,
  input wire logic [2:0] vertex_number_o,
  input wire logic       last_vertex_o
);

  // A taken transaction blocks the next one on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after an accepted transaction");

  // The last flag marks exactly the sixth vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_vertex_o == (vertex_number_o == 3'd5)))
    else $error("last_vertex disagrees with vertex_number");

  // Vertices of one rectangle come on consecutive cycles in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_vertex_o) |=>
      (valid_o && vertex_number_o == $past(vertex_number_o) + 3'd1))
    else $error("vertex sequence broken");

  // A run of vertices starts at the first corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (vertex_number_o == 3'd0))
    else $error("vertex run does not start at corner zero");

  // Vertex numbers never exceed five.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && vertex_number_o > 3'd5) |-> 1'b0)
    else $error("vertex number out of range");

endmodule

bind rotated_quad_vertex_gen_core rqvg_checker u_rqvg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .vertex_number_o(vertex_number_o),
  .last_vertex_o  (last_vertex_o)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated quad vertex generator testbench
// Feeds rectangles to the core under several screen resolutions and checks
// every emitted vertex against a fixed-point CORDIC predictor or typed positions.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STAGES  = 16;
  localparam int unsigned LATENCY = STAGES + 23;
  localparam int unsigned N_RAND  = 450;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        rgba;
    logic [2:0]         num;
    logic               last;
  } vertex_t;

  typedef struct {
    logic signed [13:0] cx;
    logic signed [13:0] cy;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [8:0]         deg;
    logic [31:0]        rgba;
    bit                 typed;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
  } rect_row_t;

  logic clk, rst_n, start, cfg_we, cfg_addr;
  logic signed [13:0] cx, cy;
  logic [11:0] rw, rh;
  logic [8:0] deg;
  logic [7:0] r, g, b, a;
  logic [12:0] cfg_wdata;
  logic busy, valid, last_v;
  logic signed [15:0] vx, vy;
  logic [7:0] orr, og, ob, oa;
  logic [2:0] vnum;

  // Model copy of the resolution registers.
  logic [12:0] res_w_q, res_h_q;
  vertex_t pending_vertices[$];
  int errors, vertices_seen, rects_sent;

  rotated_quad_vertex_gen_core #(.ROTATION_STAGES(STAGES)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .center_x_i(cx), .center_y_i(cy), .rect_width_i(rw), .rect_height_i(rh),
    .rotation_deg_i(deg), .in_red_i(r), .in_green_i(g), .in_blue_i(b),
    .in_alpha_i(a), .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr),
    .cfg_wdata_i(cfg_wdata), .valid_o(valid), .vertex_x_o(vx), .vertex_y_o(vy),
    .out_red_o(orr), .out_green_o(og), .out_blue_o(ob), .out_alpha_o(oa),
    .vertex_number_o(vnum), .last_vertex_o(last_v)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Cosine and sine in Q2.30 from a rotation-mode CORDIC.
  task automatic cordic_sincos(input logic [8:0] d, output longint c, output longint s);
    longint ang, x, y, z, xs, ys;
    bit flip;
    ang = d;
    flip = 0;
    if (ang >= 360) ang -= 360;
    if (ang > 180) ang -= 360;
    if (ang > 90) begin
      ang -= 180; flip = 1;
    end else if (ang < -90) begin
      ang += 180; flip = 1;
    end
    x = 652032874; y = 0; z = ang * 11930465;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= longint'(rqvg_pkg::atan_entry(i));
      end else begin
        x = x + ys; y = y - xs; z += longint'(rqvg_pkg::atan_entry(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Scale a numerator to Q3.12 device coordinates with rounding and saturation.
  function automatic logic signed [15:0] ndc_scale(longint num, logic [12:0] res);
    longint d, t, q, v;
    d = (res == 0 ? 1 : longint'(res)) << 18;
    t = num + d / 2;
    q = t / d;
    if (t < 0 && q * d != t) q--;
    v = q - 4096;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Queue the six vertices a rectangle should produce.
  task automatic predict_quad(input rect_row_t rq);
    longint c, s, ex, ey, nx, ny;
    vertex_t v;
    cordic_sincos(rq.deg, c, s);
    for (int k = 0; k < 6; k++) begin
      ex = rqvg_pkg::corner_x_neg(k) ? -longint'(rq.w) : longint'(rq.w);
      ey = rqvg_pkg::corner_y_neg(k) ? -longint'(rq.h) : longint'(rq.h);
      nx = (longint'(rq.cx) <<< 31) + (ex * c - ey * s);
      ny = (longint'(rq.cy) <<< 31) + (ex * s + ey * c);
      v.x = rq.typed ? rq.tx : ndc_scale(nx, res_w_q);
      v.y = rq.typed ? rq.ty : ndc_scale(ny, res_h_q);
      v.rgba = rq.rgba;
      v.num = k;
      v.last = (k == 5);
      pending_vertices.insert(pending_vertices.size(), v);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Check each vertex against the oldest prediction.
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && valid) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex number", vnum, -1);
      end else begin
        e = pending_vertices.pop_front();
        if (vx !== e.x) report_mismatch("vertex_x", vx, e.x);
        if (vy !== e.y) report_mismatch("vertex_y", vy, e.y);
        if ({orr, og, ob, oa} !== e.rgba) report_mismatch("color", {orr, og, ob, oa}, e.rgba);
        if (vnum !== e.num) report_mismatch("vertex_number", vnum, e.num);
        if (last_v !== e.last) report_mismatch("last_vertex", last_v, e.last);
      end
    end
  end

  task automatic write_res(input logic [12:0] wv, input logic [12:0] hv);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = rqvg_pkg::REG_SCREEN_WIDTH; cfg_wdata = wv;
    @(negedge clk);
    cfg_addr = rqvg_pkg::REG_SCREEN_HEIGHT; cfg_wdata = hv;
    @(negedge clk);
    cfg_we = 1'b0;
    res_w_q = wv;
    res_h_q = hv;
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Drive one rectangle and hold start until the core takes it.
  task automatic send_rect(input rect_row_t rq, input bit gaps);
    if (gaps) while ($urandom_range(0, 99) < 19) @(negedge clk);
    start = 1'b1;
    cx = rq.cx; cy = rq.cy; rw = rq.w; rh = rq.h; deg = rq.deg;
    {r, g, b, a} = rq.rgba;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_quad(rq);
    rects_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic rect_row_t rand_rect();
    rect_row_t rq;
    bit far;
    far = ($urandom_range(0, 3) == 0);
    rq.cx = far ? $urandom : $urandom_range(0, 4400) - 200;
    rq.cy = far ? $urandom : $urandom_range(0, 2600) - 200;
    rq.w = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 600);
    rq.h = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 600);
    rq.deg = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    rq.rgba = $urandom;
    rq.typed = 0;
    return rq;
  endfunction

  // Directed rectangles: zero size, extremes, every quadrant and wrapped angles.
  rect_row_t directed[] = '{
    '{0, 0, 0, 0, 0, 32'h00000000, 1, -16'sd4096, -16'sd4096},
    '{-8192, -8192, 0, 0, 0, 32'hFFFFFFFF, 1, -16'sd32768, -16'sd32768},
    '{8191, 8191, 0, 0, 0, 32'hA5A5A5A5, 1, 16'sd30852, 16'sd32767},
    '{960, 540, 4095, 4095, 0, 32'h5A5A5A5A, 0, 0, 0},
    '{960, 540, 100, 50, 45, 32'h11223344, 0, 0, 0},
    '{960, 540, 100, 50, 90, 32'h80808080, 0, 0, 0},
    '{960, 540, 100, 50, 91, 32'h7F7F7F7F, 0, 0, 0},
    '{960, 540, 100, 50, 180, 32'h01020304, 0, 0, 0},
    '{960, 540, 100, 50, 181, 32'hFF00FF00, 0, 0, 0},
    '{960, 540, 100, 50, 270, 32'h00FF00FF, 0, 0, 0},
    '{960, 540, 100, 50, 359, 32'hDEADBEEF, 0, 0, 0},
    '{960, 540, 100, 50, 360, 32'hCAFEF00D, 0, 0, 0},
    '{960, 540, 100, 50, 511, 32'h12345678, 0, 0, 0},
    '{0, 0, 4095, 0, 30, 32'h87654321, 0, 0, 0},
    '{0, 0, 0, 4095, 300, 32'h0F0F0F0F, 0, 0, 0},
    '{-1, 8191, 2048, 1, 135, 32'hF0F0F0F0, 0, 0, 0}
  };

  logic [12:0] phase_res[5][2] = '{'{1, 1}, '{4096, 4096}, '{0, 8191},
                                   '{640, 480}, '{1920, 1080}};

  initial begin
    errors = 0; vertices_seen = 0; rects_sent = 0;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
    cx = '0; cy = '0; rw = '0; rh = '0; deg = '0; r = '0; g = '0; b = '0; a = '0;
    res_w_q = rqvg_pkg::SCREEN_WIDTH_RST;
    res_h_q = rqvg_pkg::SCREEN_HEIGHT_RST;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset resolution.
    foreach (directed[i]) send_rect(directed[i], 0);
    wait_drained();

    // Random part across several resolutions, the extremes among them.
    for (int p = 0; p < 5; p++) begin
      write_res(phase_res[p][0], phase_res[p][1]);
      for (int n = 0; n < N_RAND / 5; n++) begin
        if (p == 3 && n == 40) wait_drained();
        send_rect(rand_rect(), p != 1);
      end
      wait_drained();
    end

    repeat (LATENCY + 10) @(negedge clk);
    $display("Covered %0d rectangles, %0d vertices, 6 resolution settings", rects_sent,
             vertices_seen);
    $display("including zero, 8191 and 4096 resolutions and wrapped rotations.");
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("[rotated_quad_vertex_gen_core] OK");
    end else begin
      $display("[rotated_quad_vertex_gen_core] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[rotated_quad_vertex_gen_core] ERROR");
    $finish;
  end

endmodule

FILE: rotated_quad_vertex_gen_core.f
rtl/rqvg_pkg.sv
rtl/rqvg_cordic_cell.sv
rtl/rqvg_vertex_seq.sv
rtl/rqvg_div_cell.sv
rtl/rotated_quad_vertex_gen_core.sv
rtl/rqvg_checker.sv
tb/sv/tb.sv
